// ===== hdl/piecewise_linear_inverse_cdf_sampler_unit_defines.svh =====
`ifndef PIECEWISE_LINEAR_INVERSE_CDF_SAMPLER_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_INVERSE_CDF_SAMPLER_UNIT_DEFINES_SVH
// same-cycle implication, sampled on clk, off in reset
`define PLICS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PLICS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/plics_pkg.sv =====
package plics_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int X_BITS     = 16;
  localparam int F_BITS     = 16;
  localparam int AREA_W     = 44;
  localparam int ENT_W      = X_BITS + F_BITS + AREA_W;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [X_BITS-1:0] x_value;
    logic [F_BITS-1:0] f_value;
    logic              last_point;
    logic [31:0]       uniform;
  } in_t;

  typedef struct packed {
    logic [31:0] sample_x;
    logic [9:0]  bin_index;
    logic        status;
  } out_t;

  typedef struct packed {
    logic [X_BITS-1:0] x;
    logic [F_BITS-1:0] f;
    logic [AREA_W-1:0] area;
  } ent_t;
endpackage

// ===== hdl/plics_ram.sv =====
module plics_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/plics_mul.sv =====
module plics_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic [95:0] prod,
  output logic        done
);
  logic [95:0] a_r;
  logic [31:0] b_r;
  logic [95:0] acc_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= {32'd0, a};
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign prod = acc_r;
  assign done = done_r;
endmodule

// ===== hdl/plics_sqrt.sv =====
module plics_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic [31:0] root,
  output logic        done
);
  logic [63:0] v_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_s;
  logic [35:0] trial;

  assign rem_s = {rem_r[33:0], v_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= v;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r <= v_r << 2;
      if (rem_s >= trial) begin
        rem_r  <= rem_s - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_s;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;
endmodule

// ===== hdl/plics_div.sv =====
module plics_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [79:0] num,
  input  logic [32:0] den,
  output logic [79:0] quot,
  output logic        done
);
  logic [79:0] q_r;
  logic [33:0] rem_r;
  logic [32:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [34:0] rem_s;

  assign rem_s = {rem_r, q_r[79]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd80;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (rem_s >= {2'b00, den_r}) begin
        rem_r <= 34'(rem_s - {2'b00, den_r});
        q_r   <= {q_r[78:0], 1'b1};
      end else begin
        rem_r <= rem_s[33:0];
        q_r   <= {q_r[78:0], 1'b0};
      end
    end
  end

  assign quot = q_r;
  assign done = done_r;
endmodule

// ===== hdl/piecewise_linear_inverse_cdf_sampler_unit.sv =====
// Piecewise-linear inverse-CDF sampler.
// Input channel (in_valid/in_ready/in_data): func 0 loads one table point and
// gives no result; func 1 draws one sample and gives one result transaction
// on out_valid/out_ready/out_data.
// in_ready is high only while the block is idle; one transaction is in work
// at a time. A sample on a table that is not ready or has fewer than two
// points skips the arithmetic and answers with status 1 from S_OUT.
// A valid sample scales the total area by the uniform input, walks the table
// downward in a bin search (one read of the point memory per cycle), then
// uses the serial multiplier, square root and divider in turn to place the
// sample within the bin.
// Reset clears the load index, point count and table ready flag; the table
// memory is not cleared and only entries written since are read.
// The result sits in an output register; while the receiver stalls, loads are
// still accepted, and a finished sample waits until the register frees up.
`include "piecewise_linear_inverse_cdf_sampler_unit_defines.svh"
module piecewise_linear_inverse_cdf_sampler_unit
  import plics_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TOT  = 5'd1;
  localparam logic [4:0] S_MT   = 5'd2;
  localparam logic [4:0] S_SCAN = 5'd3;
  localparam logic [4:0] S_HI   = 5'd4;
  localparam logic [4:0] S_PS   = 5'd5;
  localparam logic [4:0] S_PW   = 5'd6;
  localparam logic [4:0] S_AS   = 5'd7;
  localparam logic [4:0] S_AW   = 5'd8;
  localparam logic [4:0] S_QS   = 5'd9;
  localparam logic [4:0] S_QW   = 5'd10;
  localparam logic [4:0] S_MS   = 5'd11;
  localparam logic [4:0] S_MW   = 5'd12;
  localparam logic [4:0] S_RS   = 5'd13;
  localparam logic [4:0] S_RW   = 5'd14;
  localparam logic [4:0] S_DS   = 5'd15;
  localparam logic [4:0] S_DW   = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [4:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  load_idx_r, cnt_r;
  logic              rdy_r;
  logic [X_BITS-1:0] prev_x_r;
  logic [F_BITS-1:0] prev_f_r;
  logic [AREA_W-1:0] prev_a_r;
  logic [31:0]       u_r;
  logic [AREA_W-1:0] tgt_r, r2_r;
  logic [IDX_W-1:0]  jd_r;
  logic [X_BITS-1:0] x0_r, dx_r;
  logic [F_BITS-1:0] f0_r, adf_r;
  logic              dfneg_r;
  logic [63:0]       p_r, sq_r, d_r;
  logic [31:0]       a0_r;
  logic [32:0]       den_r;
  out_t              res_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              acc_in, is_load, is_smp, smp_err, do_wr;
  logic [X_BITS-1:0] ldx;
  logic [AREA_W-1:0] new_area;
  ent_t              wr_ent, rd_ent;
  logic [IDX_W-1:0]  raddr;
  logic              scan_go;
  logic              mul_start, mul_done, sq_start, sq_done, dv_start, dv_done;
  logic [63:0]       mul_a;
  logic [31:0]       mul_b;
  logic [95:0]       mul_p;
  logic [31:0]       sq_root;
  logic [79:0]       dv_q;
  logic [63:0]       d_calc;
  logic [31:0]       lim, offs;
  logic              slot;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign is_load  = acc_in && (in_data.func == FUNC_LOAD);
  assign is_smp   = acc_in && (in_data.func == FUNC_SAMPLE);
  assign smp_err  = !rdy_r || (cnt_r < CNT_W'(2));
  assign do_wr    = is_load && (load_idx_r < CNT_W'(MAX_POINTS));
  assign ldx      = (in_data.x_value > prev_x_r) ? in_data.x_value - prev_x_r : '0;
  assign new_area = (load_idx_r == '0) ? '0 :
                    prev_a_r + AREA_W'({1'b0, in_data.f_value} + {1'b0, prev_f_r}) *
                               AREA_W'(ldx);
  assign wr_ent   = '{x: in_data.x_value, f: in_data.f_value, area: new_area};
  assign scan_go  = (jd_r != '0) && (rd_ent.area > tgt_r);
  assign slot     = !out_valid_r || out_ready;

  always_comb begin
    unique case (state_r)
      S_IDLE:  raddr = IDX_W'(cnt_r - CNT_W'(1));
      S_MT:    raddr = IDX_W'(cnt_r - CNT_W'(2));
      S_SCAN:  raddr = scan_go ? jd_r - IDX_W'(1) : jd_r + IDX_W'(1);
      default: raddr = jd_r;
    endcase
  end

  plics_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (do_wr),
    .waddr (load_idx_r[IDX_W-1:0]),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rd_ent)
  );

  always_comb begin
    mul_start = 1'b1;
    mul_a     = 64'(rd_ent.area);
    mul_b     = u_r;
    unique case (state_r)
      S_TOT: begin
        mul_a = 64'(rd_ent.area);
        mul_b = u_r;
      end
      S_PS: begin
        mul_a = 64'(r2_r);
        mul_b = 32'(dx_r);
      end
      S_AS: begin
        mul_a = 64'(f0_r);
        mul_b = 32'(dx_r);
      end
      S_QS: begin
        mul_a = 64'(a0_r);
        mul_b = a0_r;
      end
      S_MS: begin
        mul_a = p_r;
        mul_b = 32'(adf_r);
      end
      default: mul_start = 1'b0;
    endcase
  end

  plics_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  assign sq_start = (state_r == S_RS);
  plics_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v     (d_r),
    .root  (sq_root),
    .done  (sq_done)
  );

  assign dv_start = (state_r == S_DS);
  plics_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   ({p_r, 16'd0}),
    .den   (den_r),
    .quot  (dv_q),
    .done  (dv_done)
  );

  always_comb begin
    if (!dfneg_r) begin
      d_calc = sq_r + mul_p[63:0];
    end else if (mul_p[63:0] > sq_r) begin
      d_calc = '0;
    end else begin
      d_calc = sq_r - mul_p[63:0];
    end
  end

  assign lim = {dx_r, 16'd0};
  always_comb begin
    if (den_r == '0) begin
      offs = '0;
    end else if (dv_q > 80'(lim)) begin
      offs = lim;
    end else begin
      offs = dv_q[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (is_smp) state_nxt = smp_err ? S_OUT : S_TOT;
      S_TOT:  state_nxt = S_MT;
      S_MT:   if (mul_done) state_nxt = S_SCAN;
      S_SCAN: if (!scan_go) state_nxt = S_HI;
      S_HI:   state_nxt = S_PS;
      S_PS:   state_nxt = S_PW;
      S_PW:   if (mul_done) state_nxt = S_AS;
      S_AS:   state_nxt = S_AW;
      S_AW:   if (mul_done) state_nxt = S_QS;
      S_QS:   state_nxt = S_QW;
      S_QW:   if (mul_done) state_nxt = S_MS;
      S_MS:   state_nxt = S_MW;
      S_MW:   if (mul_done) state_nxt = S_RS;
      S_RS:   state_nxt = S_RW;
      S_RW:   if (sq_done) state_nxt = S_DS;
      S_DS:   state_nxt = S_DW;
      S_DW:   if (dv_done) state_nxt = S_OUT;
      S_OUT:  if (slot) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_idx_r  <= '0;
      cnt_r       <= '0;
      rdy_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (is_load) begin
        if (in_data.last_point) begin
          cnt_r      <= (load_idx_r < CNT_W'(MAX_POINTS)) ? load_idx_r + CNT_W'(1)
                                                          : CNT_W'(MAX_POINTS);
          rdy_r      <= 1'b1;
          load_idx_r <= '0;
        end else begin
          rdy_r <= 1'b0;
          if (load_idx_r < CNT_W'(MAX_POINTS)) begin
            load_idx_r <= load_idx_r + CNT_W'(1);
          end
        end
      end
      if (state_r == S_OUT && slot) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      prev_x_r <= in_data.x_value;
      prev_f_r <= in_data.f_value;
      prev_a_r <= new_area;
    end
    if (is_smp) begin
      u_r   <= in_data.uniform;
      res_r <= '{sample_x: '0, bin_index: '0, status: 1'b1};
    end
    if (state_r == S_MT && mul_done) begin
      tgt_r <= mul_p[AREA_W+31:32];
      jd_r  <= IDX_W'(cnt_r - CNT_W'(2));
    end
    if (state_r == S_SCAN) begin
      if (scan_go) begin
        jd_r <= jd_r - IDX_W'(1);
      end else begin
        x0_r <= rd_ent.x;
        f0_r <= rd_ent.f;
        r2_r <= tgt_r - rd_ent.area;
      end
    end
    if (state_r == S_HI) begin
      dx_r    <= (rd_ent.x > x0_r) ? rd_ent.x - x0_r : '0;
      dfneg_r <= rd_ent.f < f0_r;
      adf_r   <= (rd_ent.f < f0_r) ? f0_r - rd_ent.f : rd_ent.f - f0_r;
    end
    if (state_r == S_PW && mul_done) p_r <= mul_p[63:0];
    if (state_r == S_AW && mul_done) a0_r <= mul_p[31:0];
    if (state_r == S_QW && mul_done) sq_r <= mul_p[63:0];
    if (state_r == S_MW && mul_done) d_r <= d_calc;
    if (state_r == S_RW && sq_done) den_r <= {1'b0, a0_r} + {1'b0, sq_root};
    if (state_r == S_DW && dv_done) begin
      res_r <= '{sample_x: {x0_r, 16'd0} + offs, bin_index: 10'(jd_r), status: 1'b0};
    end
    if (state_r == S_OUT && slot) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLICS_ASSERT_NOW(a_idx_bound, 1'b1, load_idx_r <= CNT_W'(MAX_POINTS), "load index overrun")
  `PLICS_ASSERT_NOW(a_ready_cnt, rdy_r, cnt_r != '0, "ready table with no points")
  `PLICS_ASSERT_NOW(a_scan_rng, state_r == S_SCAN, CNT_W'(jd_r) + CNT_W'(2) <= cnt_r,
                    "bin search outside table")
  `PLICS_ASSERT_NOW(a_mul_done, mul_done,
                    state_r == S_MT || state_r == S_PW || state_r == S_AW ||
                    state_r == S_QW || state_r == S_MW, "multiplier done out of phase")
  `PLICS_ASSERT_NXT(a_out_load, state_r == S_OUT && slot, out_valid_r,
                    "finished result not presented")
endmodule
